@@ rtl/aqi_pkg.sv @@
// Package for the air quality index core: item types, pollutant codes and the
// per-pollutant breakpoint tables with their reciprocal divisors.
// No dependencies.
`timescale 1ns / 1ps

package aqi_pkg;

  localparam int BANDS = 6;
  localparam int ROWS = 6;
  localparam int LIMIT = (BANDS < ROWS) ? BANDS : ROWS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int LANE_STAGES = 4;

  localparam int CONC_W = 16;
  localparam int INDEX_W = 9;
  localparam int DIFF_W = 13;
  localparam int SCALE_W = 7;
  localparam int NUM_W = DIFF_W + SCALE_W;
  localparam int RECIP_W = 30;
  localparam int RECIP_SHIFT = 33;
  localparam int QUOT_W = SCALE_W;

  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;

  typedef enum logic [1:0] {
    POL_CO,
    POL_NH4,
    POL_PM25
  } pollutant_t;

  typedef struct packed {
    logic [CONC_W-1:0] co_tenths;
    logic [CONC_W-1:0] nh4_tenths;
    logic [CONC_W-1:0] pm25_tenths;
  } sample_t;

  typedef struct packed {
    logic [INDEX_W-1:0] co_index;
    logic [INDEX_W-1:0] nh4_index;
    logic [INDEX_W-1:0] pm25_index;
    logic [INDEX_W-1:0] overall_index;
  } result_t;

  typedef struct packed {
    logic [CONC_W-1:0]  c_lo;
    logic [CONC_W:0]    c_hi;
    logic [INDEX_W-1:0] i_lo;
    logic [INDEX_W-1:0] i_hi;
    logic [RECIP_W-1:0] recip;
    logic               wide;
  } band_t;

  localparam logic [CONC_W:0] HI_OPEN = '1;

  localparam band_t CO_TAB [ROWS] = '{
    '{16'd0,   17'd10,  9'd0,   9'd50,  RECIP_W'(RECIP_ONE / 64'd10 + 64'd1),  1'b0},
    '{16'd11,  17'd20,  9'd51,  9'd100, RECIP_W'(RECIP_ONE / 64'd9 + 64'd1),   1'b0},
    '{16'd21,  17'd100, 9'd101, 9'd200, RECIP_W'(RECIP_ONE / 64'd79 + 64'd1),  1'b0},
    '{16'd101, 17'd170, 9'd201, 9'd300, RECIP_W'(RECIP_ONE / 64'd69 + 64'd1),  1'b0},
    '{16'd171, 17'd340, 9'd301, 9'd400, RECIP_W'(RECIP_ONE / 64'd169 + 64'd1), 1'b0},
    '{16'd340, HI_OPEN, 9'd401, 9'd500, '0, 1'b1}
  };

  localparam band_t NH4_TAB [ROWS] = '{
    '{16'd0,     17'd2000,  9'd0,   9'd50,  RECIP_W'(RECIP_ONE / 64'd2000 + 64'd1), 1'b0},
    '{16'd2010,  17'd4000,  9'd51,  9'd100, RECIP_W'(RECIP_ONE / 64'd1990 + 64'd1), 1'b0},
    '{16'd4010,  17'd8000,  9'd101, 9'd200, RECIP_W'(RECIP_ONE / 64'd3990 + 64'd1), 1'b0},
    '{16'd8010,  17'd12000, 9'd201, 9'd300, RECIP_W'(RECIP_ONE / 64'd3990 + 64'd1), 1'b0},
    '{16'd12011, 17'd18000, 9'd301, 9'd400, RECIP_W'(RECIP_ONE / 64'd5989 + 64'd1), 1'b0},
    '{16'd18000, HI_OPEN,   9'd401, 9'd500, '0, 1'b1}
  };

  localparam band_t PM25_TAB [ROWS] = '{
    '{16'd0,    17'd300,  9'd0,   9'd50,  RECIP_W'(RECIP_ONE / 64'd300 + 64'd1),  1'b0},
    '{16'd310,  17'd600,  9'd51,  9'd100, RECIP_W'(RECIP_ONE / 64'd290 + 64'd1),  1'b0},
    '{16'd610,  17'd900,  9'd101, 9'd200, RECIP_W'(RECIP_ONE / 64'd290 + 64'd1),  1'b0},
    '{16'd910,  17'd1200, 9'd201, 9'd300, RECIP_W'(RECIP_ONE / 64'd290 + 64'd1),  1'b0},
    '{16'd1211, 17'd2500, 9'd301, 9'd400, RECIP_W'(RECIP_ONE / 64'd1289 + 64'd1), 1'b0},
    '{16'd2510, HI_OPEN,  9'd401, 9'd500, '0, 1'b1}
  };

  function automatic band_t band_of(input pollutant_t pol, input logic [ROW_W-1:0] row);
    band_t b;
    b = CO_TAB[row];
    case (pol)
      POL_CO: b = CO_TAB[row];
      POL_NH4: b = NH4_TAB[row];
      POL_PM25: b = PM25_TAB[row];
      default: b = CO_TAB[row];
    endcase
    return b;
  endfunction

endpackage

@@ rtl/aqi_lane.sv @@
// One pollutant lane: band search, clamp, scale, reciprocal divide, offset.
// Depends on aqi_pkg for the breakpoint tables and widths.
`timescale 1ns / 1ps

module aqi_lane (
  input  logic                            clk,
  input  aqi_pkg::pollutant_t             pollutant,
  input  logic [aqi_pkg::CONC_W-1:0]      conc,
  output logic [aqi_pkg::INDEX_W-1:0]     index
);

  logic [aqi_pkg::ROW_W-1:0]       pick;
  aqi_pkg::band_t                  scan_band;
  aqi_pkg::band_t                  pick_band;
  logic [aqi_pkg::CONC_W-1:0]      clamped;
  logic [aqi_pkg::ROW_W-1:0]       row1;
  logic [aqi_pkg::DIFF_W-1:0]      diff1;
  logic [aqi_pkg::ROW_W-1:0]       row2;
  logic [aqi_pkg::NUM_W-1:0]       num2;
  logic [aqi_pkg::ROW_W-1:0]       row3;
  logic [aqi_pkg::QUOT_W-1:0]      quot3;
  aqi_pkg::band_t                  band1;
  aqi_pkg::band_t                  band2;
  aqi_pkg::band_t                  band3;
  logic [aqi_pkg::SCALE_W-1:0]     scale1;
  logic [aqi_pkg::NUM_W+aqi_pkg::RECIP_W-1:0] prod2;

  always_comb begin
    pick = aqi_pkg::ROW_W'(aqi_pkg::LIMIT - 1);
    scan_band = aqi_pkg::band_of(pollutant, pick);
    for (int r = aqi_pkg::LIMIT - 1; r >= 0; r--) begin
      scan_band = aqi_pkg::band_of(pollutant, aqi_pkg::ROW_W'(r));
      if (scan_band.c_hi >= {1'b0, conc}) begin
        pick = aqi_pkg::ROW_W'(r);
      end
    end
    pick_band = aqi_pkg::band_of(pollutant, pick);
    clamped = conc;
    if ({1'b0, conc} > pick_band.c_hi) begin
      clamped = pick_band.c_hi[aqi_pkg::CONC_W-1:0];
    end
    if (clamped < pick_band.c_lo) begin
      clamped = pick_band.c_lo;
    end
  end

  always_ff @(posedge clk) begin
    row1 <= pick;
    diff1 <= pick_band.wide ? '0 : aqi_pkg::DIFF_W'(clamped - pick_band.c_lo);
  end

  assign band1 = aqi_pkg::band_of(pollutant, row1);
  assign scale1 = aqi_pkg::SCALE_W'(band1.i_hi - band1.i_lo);

  always_ff @(posedge clk) begin
    row2 <= row1;
    num2 <= aqi_pkg::NUM_W'(diff1 * scale1);
  end

  assign band2 = aqi_pkg::band_of(pollutant, row2);
  assign prod2 = num2 * band2.recip;

  always_ff @(posedge clk) begin
    row3 <= row2;
    quot3 <= prod2[aqi_pkg::RECIP_SHIFT +: aqi_pkg::QUOT_W];
  end

  assign band3 = aqi_pkg::band_of(pollutant, row3);

  always_ff @(posedge clk) begin
    index <= aqi_pkg::INDEX_W'(band3.i_lo + {2'b00, quot3});
  end

endmodule

@@ rtl/aqi_merge.sv @@
// Merging stage: registers the three sub-indices with their maximum and the strobe.
// Depends on aqi_pkg for the result item type.
`timescale 1ns / 1ps

module aqi_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  logic [aqi_pkg::INDEX_W-1:0] co_idx,
  input  logic [aqi_pkg::INDEX_W-1:0] nh4_idx,
  input  logic [aqi_pkg::INDEX_W-1:0] pm25_idx,
  output logic                        done,
  output aqi_pkg::result_t            result
);

  logic [aqi_pkg::INDEX_W-1:0] top_ab;
  logic [aqi_pkg::INDEX_W-1:0] top_all;

  assign top_ab = (nh4_idx > co_idx) ? nh4_idx : co_idx;
  assign top_all = (pm25_idx > top_ab) ? pm25_idx : top_ab;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    result.co_index <= co_idx;
    result.nh4_index <= nh4_idx;
    result.pm25_index <= pm25_idx;
    result.overall_index <= top_all;
  end

  a_overall_is_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.overall_index >= result.co_index) &&
             (result.overall_index >= result.nh4_index) &&
             (result.overall_index >= result.pm25_index))
    else $error("overall index below a sub-index");

  a_overall_is_member: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.overall_index == result.co_index) ||
             (result.overall_index == result.nh4_index) ||
             (result.overall_index == result.pm25_index))
    else $error("overall index matches no sub-index");

endmodule

@@ rtl/aqi_breakpoint_index_core.sv @@
// Top level of the air quality index core: three pollutant lanes and a merging stage.
// Depends on aqi_pkg, aqi_lane and aqi_merge.
// done strobes a result once its item has passed the lane pipeline and the merging stage.
// Throughput: one item per cycle; busy is never raised and every stage is a plain register.
// The lane pipeline registers search, scale multiply, reciprocal multiply and offset in order.
// Reset clears the valid pipeline and the done strobe; data registers are not reset.
`timescale 1ns / 1ps

module aqi_breakpoint_index_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aqi_pkg::sample_t sample,
  output logic             done,
  output aqi_pkg::result_t result
);

  logic [aqi_pkg::LANE_STAGES-1:0] valid_pipe;
  logic [aqi_pkg::INDEX_W-1:0]     co_idx;
  logic [aqi_pkg::INDEX_W-1:0]     nh4_idx;
  logic [aqi_pkg::INDEX_W-1:0]     pm25_idx;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[aqi_pkg::LANE_STAGES-2:0], start && !busy};
    end
  end

  aqi_lane u_co_lane (
    .clk       (clk),
    .pollutant (aqi_pkg::POL_CO),
    .conc      (sample.co_tenths),
    .index     (co_idx)
  );

  aqi_lane u_nh4_lane (
    .clk       (clk),
    .pollutant (aqi_pkg::POL_NH4),
    .conc      (sample.nh4_tenths),
    .index     (nh4_idx)
  );

  aqi_lane u_pm25_lane (
    .clk       (clk),
    .pollutant (aqi_pkg::POL_PM25),
    .conc      (sample.pm25_tenths),
    .index     (pm25_idx)
  );

  aqi_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .valid    (valid_pipe[aqi_pkg::LANE_STAGES-1]),
    .co_idx   (co_idx),
    .nh4_idx  (nh4_idx),
    .pm25_idx (pm25_idx),
    .done     (done),
    .result   (result)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, aqi_pkg::LANE_STAGES + 1))
    else $error("result strobed without an accepted item");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(aqi_pkg::LANE_STAGES + 1) done)
    else $error("accepted item produced no result");

endmodule
